/* sv/tdr_pkg.sv */
// Shared types, constants and the stage coefficient table for the development rate block.
package tdr_pkg;

  localparam int STAGE_COUNT = 8;
  localparam int ROW_COUNT   = 8;

  localparam int STAGE_W     = 3;
  localparam int TEMP_W      = 15;
  localparam int RATE_W      = 16;
  localparam int MEAN_W      = 15;
  localparam int SIGMA_W     = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // Exponential unit: Q16 argument in, Q16 result out.
  localparam int EXP_IN_W  = 26;
  localparam int EXP_OUT_W = 35;
  localparam int LN2_Q16   = 45426;
  localparam longint EXP_RECIP = (64'd1 << 32) / LN2_Q16;
  localparam int EXP_K_OFS = 24;
  localparam int EXP_OFS   = EXP_K_OFS * LN2_Q16;
  localparam int EXP_LO    = -16 * 65536;
  localparam int EXP_HI    = 12 * 65536;
  localparam int EXP_SHIFT_BASE = EXP_K_OFS + 14;
  localparam int ONE_Q30   = 1 << 30;
  localparam int EXP_STEPS = 6;

  localparam int FRONT_LAT = 5;
  localparam int EXP_LAT   = 3 + 3 * EXP_STEPS;
  localparam int BACK_LAT  = 3;
  localparam int PIPE_LAT  = FRONT_LAT + EXP_LAT + BACK_LAT;

  typedef struct packed {
    logic signed [15:0] tb;
    logic signed [15:0] tm;
    logic [20:0]        inv_span;
    logic [20:0]        inv_db;
    logic [14:0]        inv_dm;
    logic [14:0]        omega;
    logic [19:0]        psi;
    logic [15:0]        sigma;
    logic [14:0]        mean;
  } coef_t;

  // Per-item information that rides beside the exponential units.
  typedef struct packed {
    logic        ok;
    logic        inr;
    logic [16:0] ratio_b;
    logic [16:0] ratio_c;
    logic [19:0] psi;
    logic [14:0] mean;
    logic [15:0] sigma;
  } side_t;

  function automatic coef_t coef_lookup(input logic [STAGE_W-1:0] idx);
    coef_t c;
    case (idx)
      3'd0: c = '{16'sd1843, 16'sd10214, 21'd513065, 21'd38551, 15'd7533, 15'd7143,
                  20'd786851, 16'd4601, 15'd256};
      3'd1: c = '{16'sd922, 16'sd7501, 21'd652810, 21'd655360, 15'd17246, 15'd15729,
                  20'd181529, 16'd19078, 15'd256};
      3'd2: c = '{16'sd1792, 16'sd7398, 21'd766083, 21'd655360, 15'd21845, 15'd24314,
                  20'd107710, 16'd24904, 15'd256};
      3'd3: c = '{16'sd1741, 16'sd7347, 21'd766083, 21'd655360, 15'd26214, 15'd28836,
                  20'd65263, 16'd25362, 15'd256};
      3'd4: c = '{16'sd4147, 16'sd7168, 21'd1421798, 21'd1638400, 15'd14247, 15'd16974,
                  20'd843894, 16'd25756, 15'd256};
      3'd5: c = '{16'sd1434, 16'sd7296, 21'd732630, 21'd595782, 15'd22599, 15'd10027,
                  20'd343933, 16'd19661, 15'd256};
      3'd6: c = '{16'sd1075, 16'sd8960, 21'd544715, 21'd655360, 15'd9230, 15'd9568,
                  20'd196293, 16'd34603, 15'd256};
      3'd7: c = '{16'sd1178, 16'sd7117, 21'd723156, 21'd655360, 15'd21141, 15'd24117,
                  20'd87242, 16'd16122, 15'd20941};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* sv/tdr_front.sv */
// Front stages: coefficient lookup, range check, exponent arguments and ratios.
module tdr_front #(
  parameter int STAGE_COUNT = tdr_pkg::STAGE_COUNT
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [tdr_pkg::STAGE_W-1:0]           stage,
  input  logic signed [tdr_pkg::TEMP_W-1:0]     temperature,
  output logic signed [tdr_pkg::EXP_IN_W-1:0]   arg_a,
  output logic signed [tdr_pkg::EXP_IN_W-1:0]   arg_b,
  output logic signed [tdr_pkg::EXP_IN_W-1:0]   arg_c,
  output tdr_pkg::side_t                        side
);

  // F0: input capture.
  logic [tdr_pkg::STAGE_W-1:0]       stage0;
  logic signed [tdr_pkg::TEMP_W-1:0] temp0;

  // F1: row and differences.
  tdr_pkg::coef_t row_w;
  logic signed [16:0] d_w, up_w, span_w;
  tdr_pkg::coef_t row1;
  logic [13:0] d1, up1, span1;
  logic inr1, ok1;

  // F2: products.
  logic [28:0] arga_p, dm_p, oms_p;
  logic [34:0] rb_p, rc_p;
  tdr_pkg::coef_t row2;
  logic [19:0] arga2, oms2;
  logic [20:0] dm2;
  logic [18:0] rb2, rc2;
  logic inr2, ok2;

  // F3: second product and clamps.
  logic [40:0] argb_p;
  logic [24:0] argb3;
  logic signed [21:0] argc3;
  logic [19:0] arga3;
  tdr_pkg::side_t side3;

  always_comb begin
    row_w  = tdr_pkg::coef_lookup(stage0);
    d_w    = 17'(temp0) - 17'(row_w.tb);
    up_w   = 17'(row_w.tm) - 17'(temp0);
    span_w = 17'(row_w.tm) - 17'(row_w.tb);
    arga_p = 29'(row1.omega) * 29'(d1);
    dm_p   = 29'(up1) * 29'(row1.inv_dm);
    oms_p  = 29'(row1.omega) * 29'(span1);
    rb_p   = 35'(up1) * 35'(row1.inv_span);
    rc_p   = 35'(d1) * 35'(row1.inv_span);
    argb_p = 41'(arga2) * 41'(row2.inv_db);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage0 <= stage;
      temp0  <= temperature;

      row1  <= row_w;
      d1    <= d_w[13:0];
      up1   <= up_w[13:0];
      span1 <= span_w[13:0];
      inr1  <= (d_w >= 0) && (up_w >= 0);
      ok1   <= int'(stage0) < STAGE_COUNT;

      row2  <= row1;
      arga2 <= arga_p[27:8];
      dm2   <= dm_p[28:8];
      oms2  <= oms_p[27:8];
      rb2   <= rb_p[34:16];
      rc2   <= rc_p[34:16];
      inr2  <= inr1;
      ok2   <= ok1;

      argb3 <= argb_p[40:16];
      argc3 <= $signed({2'b00, oms2}) - $signed({1'b0, dm2});
      arga3 <= arga2;
      side3.ok      <= ok2;
      side3.inr     <= inr2;
      side3.ratio_b <= (rb2 > 19'd65536) ? 17'd65536 : rb2[16:0];
      side3.ratio_c <= (rc2 > 19'd65536) ? 17'd65536 : rc2[16:0];
      side3.psi     <= row2.psi;
      side3.mean    <= row2.mean;
      side3.sigma   <= row2.sigma;

      arg_a <= $signed(tdr_pkg::EXP_IN_W'(arga3));
      arg_b <= -$signed(tdr_pkg::EXP_IN_W'(argb3));
      arg_c <= tdr_pkg::EXP_IN_W'(argc3);
      side  <= side3;
    end
  end

endmodule

/* sv/tdr_exp.sv */
// Pipelined fixed-point exponential: range reduction by ln2, Horner series, final shift.
module tdr_exp (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [tdr_pkg::EXP_IN_W-1:0]  x,
  output logic [tdr_pkg::EXP_OUT_W-1:0]        y
);

  localparam int NS = tdr_pkg::EXP_STEPS;

  logic signed [tdr_pkg::EXP_IN_W-1:0] xc;
  logic [20:0] xp_w;
  logic [37:0] q_p;
  logic [20:0] xp0;
  logic [5:0]  q0;
  logic        z0;

  logic [20:0] qlx, rem_w;
  logic [15:0] r1;
  logic [5:0]  q1;
  logic        z1;

  logic [31:0] ts [0:NS];
  logic [15:0] rs [0:NS];
  logic [5:0]  qs [0:NS];
  logic        zs [0:NS];

  logic [tdr_pkg::EXP_OUT_W-1:0] y_w;

  always_comb begin
    if (x > tdr_pkg::EXP_HI) begin
      xc = tdr_pkg::EXP_IN_W'(tdr_pkg::EXP_HI);
    end else if (x < tdr_pkg::EXP_LO) begin
      xc = tdr_pkg::EXP_IN_W'(tdr_pkg::EXP_LO);
    end else begin
      xc = x;
    end
    // Offset by a whole number of ln2 so the quotient is never negative.
    xp_w  = 21'(xc + tdr_pkg::EXP_IN_W'(tdr_pkg::EXP_OFS));
    q_p   = 38'(xp_w) * 38'(tdr_pkg::EXP_RECIP);
    qlx   = 21'(q0) * 21'(tdr_pkg::LN2_Q16);
    rem_w = xp0 - qlx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp0 <= xp_w;
      q0  <= q_p[37:32];
      z0  <= x < tdr_pkg::EXP_LO;
      if (rem_w >= 21'(tdr_pkg::LN2_Q16)) begin
        r1 <= 16'(rem_w - 21'(tdr_pkg::LN2_Q16));
        q1 <= q0 + 6'd1;
      end else begin
        r1 <= rem_w[15:0];
        q1 <= q0;
      end
      z1 <= z0;
    end
  end

  assign ts[0] = 32'(tdr_pkg::ONE_Q30);
  assign rs[0] = r1;
  assign qs[0] = q1;
  assign zs[0] = z1;

  // Each Horner step: multiply, reciprocal multiply, then remainder fix and add one.
  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int DIV = NS - j;
    localparam logic [32:0] RECIP = 33'((65'd1 << 32) / DIV);

    logic [61:0] prod_a;
    logic [64:0] prod_b;
    logic [34:0] mul_c, rem_c;
    logic [31:0] qadj;
    logic [31:0] pa, pb, qqb, tc;
    logic [15:0] ra, rb, rc;
    logic [5:0]  qa, qb, qc;
    logic        za, zb, zc;

    always_comb begin
      prod_a = 62'({rs[j], 14'b0}) * 62'(ts[j]);
      prod_b = 65'(pa) * 65'(RECIP);
      mul_c  = 35'(qqb) * 35'(DIV);
      rem_c  = 35'(pb) - mul_c;
      qadj   = (rem_c >= 35'(DIV)) ? qqb + 32'd1 : qqb;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa  <= prod_a[61:30];
        ra  <= rs[j];
        qa  <= qs[j];
        za  <= zs[j];
        pb  <= pa;
        qqb <= prod_b[63:32];
        rb  <= ra;
        qb  <= qa;
        zb  <= za;
        tc  <= 32'(tdr_pkg::ONE_Q30) + qadj;
        rc  <= rb;
        qc  <= qb;
        zc  <= zb;
      end
    end

    assign ts[j+1] = tc;
    assign rs[j+1] = rc;
    assign qs[j+1] = qc;
    assign zs[j+1] = zc;
  end

  always_comb begin
    if (zs[NS]) begin
      y_w = '0;
    end else if (qs[NS] >= 6'(tdr_pkg::EXP_SHIFT_BASE)) begin
      y_w = tdr_pkg::EXP_OUT_W'(ts[NS]) << (qs[NS] - 6'(tdr_pkg::EXP_SHIFT_BASE));
    end else begin
      y_w = tdr_pkg::EXP_OUT_W'(ts[NS] >> (6'(tdr_pkg::EXP_SHIFT_BASE) - qs[NS]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_w;
    end
  end

endmodule

/* sv/tdr_back.sv */
// Back stages: weighted correction terms, difference, scale by psi and saturation.
module tdr_back (
  input  logic                              clk,
  input  logic                              en,
  input  tdr_pkg::side_t                    side_in,
  input  logic [tdr_pkg::EXP_OUT_W-1:0]     exp_a,
  input  logic [tdr_pkg::EXP_OUT_W-1:0]     exp_b,
  input  logic [tdr_pkg::EXP_OUT_W-1:0]     exp_c,
  output logic [tdr_pkg::RATE_W-1:0]        rate,
  output logic [tdr_pkg::MEAN_W-1:0]        relative_mean,
  output logic [tdr_pkg::SIGMA_W-1:0]       relative_sigma
);

  logic [33:0] tb_p;
  logic [51:0] tc_p;
  logic [34:0] ta1;
  logic [17:0] tb1;
  logic [35:0] tc1;
  tdr_pkg::side_t side1, side2, side3;

  logic signed [37:0] diff_w;
  logic [25:0] d2;
  logic pos2, big2;

  logic [45:0] prod_w;
  logic [21:0] p3;
  logic pos3, big3;

  always_comb begin
    // The decaying term never exceeds one, so its low 17 bits carry it all.
    tb_p   = 34'(side_in.ratio_b) * 34'(exp_b[16:0]);
    tc_p   = 52'(side_in.ratio_c) * 52'(exp_c);
    diff_w = $signed(38'(ta1)) - $signed(38'(tb1)) - $signed(38'(tc1));
    prod_w = 46'(side2.psi) * 46'(d2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta1   <= exp_a;
      tb1   <= tb_p[33:16];
      tc1   <= tc_p[51:16];
      side1 <= side_in;

      d2    <= diff_w[25:0];
      pos2  <= diff_w > 0;
      // Any psi in the table times 2^26 is past one in Q0.16.
      big2  <= (diff_w > 0) && (diff_w[36:26] != '0);
      side2 <= side1;

      p3    <= prod_w[45:24];
      pos3  <= pos2;
      big3  <= big2;
      side3 <= side2;
    end
  end

  always_comb begin
    if (!(side3.ok && side3.inr && pos3)) begin
      rate = '0;
    end else if (big3 || (p3[21:16] != '0)) begin
      rate = '1;
    end else begin
      rate = p3[15:0];
    end
    relative_mean  = side3.ok ? side3.mean : '0;
    relative_sigma = side3.ok ? side3.sigma : '0;
  end

endmodule

/* sv/temperature_development_rate_top.sv */
// Top level of the temperature driven development rate pipeline.
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata: stage[2:0], temperature[17:3]
//  m_*      out        tdata: rate[15:0], relative_mean[30:16], relative_sigma[46:31]
//
// One beat enters per cycle while the output is not stalled; m_tvalid rises once the
// accepted beat has passed the front, exponential and back stages.
// The depth is set by the exponential units: ln2 reduction plus six Horner
// steps of three stages each, with front and back stages around them.
// Reset clears only the valid bits. When m_tready is low and the output
// register is full, the whole pipeline holds and s_tready drops.
module temperature_development_rate_top #(
  parameter int STAGE_COUNT = tdr_pkg::STAGE_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tdr_pkg::IN_TDATA_W-1:0]      s_tdata,   // stage, temperature
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tdr_pkg::OUT_TDATA_W-1:0]     m_tdata    // rate, relative_mean, relative_sigma
);

  localparam int PL = tdr_pkg::PIPE_LAT;
  localparam int EL = tdr_pkg::EXP_LAT;

  logic adv;
  logic [PL-1:0] vld;

  logic signed [tdr_pkg::EXP_IN_W-1:0] arg_a, arg_b, arg_c;
  logic [tdr_pkg::EXP_OUT_W-1:0] exp_a, exp_b, exp_c;
  tdr_pkg::side_t side_f;
  tdr_pkg::side_t side_dly [0:EL-1];

  logic [tdr_pkg::RATE_W-1:0]  rate;
  logic [tdr_pkg::MEAN_W-1:0]  relative_mean;
  logic [tdr_pkg::SIGMA_W-1:0] relative_sigma;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  tdr_front #(.STAGE_COUNT(STAGE_COUNT)) u_front (
    .clk         (clk),
    .en          (adv),
    .stage       (s_tdata[2:0]),
    .temperature ($signed(s_tdata[17:3])),
    .arg_a       (arg_a),
    .arg_b       (arg_b),
    .arg_c       (arg_c),
    .side        (side_f)
  );

  tdr_exp u_exp_a (.clk(clk), .en(adv), .x(arg_a), .y(exp_a));
  tdr_exp u_exp_b (.clk(clk), .en(adv), .x(arg_b), .y(exp_b));
  tdr_exp u_exp_c (.clk(clk), .en(adv), .x(arg_c), .y(exp_c));

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly[0] <= side_f;
      for (int i = 1; i < EL; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  tdr_back u_back (
    .clk            (clk),
    .en             (adv),
    .side_in        (side_dly[EL-1]),
    .exp_a          (exp_a),
    .exp_b          (exp_b),
    .exp_c          (exp_c),
    .rate           (rate),
    .relative_mean  (relative_mean),
    .relative_sigma (relative_sigma)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[PL-2:0], s_tvalid};
      m_tvalid <= vld[PL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {1'b0, relative_sigma, relative_mean, rate};
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47] == 1'b0)
    else $error("output padding bit set");

  a_rate_has_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:0] != '0) |-> m_tdata[46:31] != '0)
    else $error("nonzero rate from a stage without a row");

endmodule

/* test/temperature_development_rate_top_tb.sv */
// Self-checking testbench for the temperature driven development rate pipeline.
`timescale 1ns / 100ps

// Keeps the rates expected from accepted beats and compares the results that come back.
class dev_rate_scoreboard;
  logic [47:0] pending_q[$];
  int errors;
  int results_seen;

  // Q16 exponential: ln2 range reduction and a degree six series in Q30.
  function automatic longint exp_fixed(longint x);
    longint k, r, sh;
    longint unsigned r30, t;
    if (x < -64'sd16 * 65536) return 0;
    if (x > 64'sd12 * 65536) x = 64'sd12 * 65536;
    k = x / tdr_pkg::LN2_Q16;
    r = x - k * tdr_pkg::LN2_Q16;
    if (r < 0) begin
      k -= 1;
      r += tdr_pkg::LN2_Q16;
    end
    r30 = longint'(r) << 14;
    t = 64'd1 << 30;
    for (int i = 6; i >= 1; i--) t = (64'd1 << 30) + ((r30 * t) >> 30) / i;
    sh = k - 14;
    if (sh >= 0) return longint'(t << sh);
    return longint'(t >> (-sh));
  endfunction

  function automatic longint clamp_ratio(longint diff, longint inv);
    longint q;
    q = (diff * inv) >>> 16;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic logic [47:0] predict_rate(logic [2:0] stage, logic signed [14:0] temp);
    tdr_pkg::coef_t c;
    longint t8, d8, up8, span8, arg_a, arg_b, arg_c, ta, tbv, tcv, diff;
    longint unsigned rate;
    rate = 0;
    if (stage >= tdr_pkg::STAGE_COUNT) return '0;
    c = tdr_pkg::coef_lookup(stage);
    t8 = temp;
    if (t8 >= c.tb && t8 <= c.tm) begin
      d8 = t8 - c.tb;
      up8 = c.tm - t8;
      span8 = c.tm - c.tb;
      arg_a = (longint'(c.omega) * d8) >>> 8;
      arg_b = -((arg_a * longint'(c.inv_db)) >>> 16);
      arg_c = ((longint'(c.omega) * span8) >>> 8) - ((up8 * longint'(c.inv_dm)) >>> 8);
      ta = exp_fixed(arg_a);
      tbv = (clamp_ratio(up8, c.inv_span) * exp_fixed(arg_b)) >>> 16;
      tcv = (clamp_ratio(d8, c.inv_span) * exp_fixed(arg_c)) >>> 16;
      diff = ta - tbv - tcv;
      if (diff > 0) begin
        rate = (longint'(c.psi) * diff) >> 24;
        if (rate > 65535) rate = 65535;
      end
    end
    return {1'b0, c.sigma, c.mean, rate[15:0]};
  endfunction

  function void note_input(logic [23:0] beat);
    pending_q.push_back(predict_rate(beat[2:0], beat[17:3]));
  endfunction

  function void check_result(logic [47:0] beat);
    logic [47:0] want;
    results_seen++;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h", beat);
      return;
    end
    want = pending_q.pop_front();
    if (beat[15:0] !== want[15:0] || beat[30:16] !== want[30:16]
        || beat[46:31] !== want[46:31]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: rate %0d/%0d mean %0d/%0d sigma %0d/%0d (expected/actual)",
                 want[15:0], beat[15:0], want[30:16], beat[30:16],
                 want[46:31], beat[46:31]);
    end
  endfunction
endclass

module temperature_development_rate_top_tb;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;

  dev_rate_scoreboard board = new();
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;
  int beats_sent;

  temperature_development_rate_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side: checks accepted beats and stalls at random.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one beat, with a random idle gap first, and waits for acceptance.
  // tvalid stays high from one beat to the next unless the sender idles.
  task automatic send_temp(logic [2:0] stage, logic [14:0] temp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'd0, temp, stage};
    do @(posedge clk); while (!s_tready);
    board.note_input({6'd0, temp, stage});
    beats_sent++;
  endtask

  task automatic send_random(int count);
    tdr_pkg::coef_t c;
    logic [2:0] st;
    int t;
    repeat (count) begin
      st = 3'($urandom_range(7));
      c = tdr_pkg::coef_lookup(st);
      case ($urandom_range(9))
        0: t = $urandom_range(32767) - 16384;  // any code, including off the nominal range
        1: t = $urandom_range(25600) - 10240;
        default: t = $urandom_range(c.tm - c.tb) + c.tb;  // inside the stage's window
      endcase
      send_temp(st, t[14:0]);
    end
  endtask

  initial begin
    tdr_pkg::coef_t c;
    send_idle_pct = 12;
    recv_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: field extremes, window edges of every stage, saturation region.
    send_temp(3'd0, 15'h4000);
    send_temp(3'd7, 15'h3fff);
    send_temp(3'd0, -15'sd10240);
    send_temp(3'd4, 15'd15360);
    for (int s = 0; s < 8; s++) begin
      c = tdr_pkg::coef_lookup(s[2:0]);
      send_temp(s[2:0], c.tb[14:0]);
      send_temp(s[2:0], c.tm[14:0]);
      if (s < 4) send_temp(s[2:0], 15'(c.tm - 1));
    end
    send_temp(3'd4, 15'd6800);
    send_random(550);
    send_idle_pct = 85;
    recv_idle_pct = 12;
    send_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(580);
    s_tvalid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (tdr_pkg::PIPE_LAT + 10) @(posedge clk);
    $display("sent %0d beats over all stages, window edges and out-of-range codes", beats_sent);
    $display("checked %0d results, %0d mismatches", board.results_seen, board.errors);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
